// File: hw/rtl/srmt_pkg.sv
package srmt_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int LAP_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FILTER = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_EXT,
    ACT_MERGE,
    ACT_INS
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_ADD_DECIDE,
    ST_MERGE_A,
    ST_MERGE_B,
    ST_ADD_APPLY,
    ST_FILT_LAP,
    ST_FILT_PACK,
    ST_READ_LAP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [63:0] phys;
    logic [63:0] virt;
    logic [63:0] span;
  } entry_t;

  // rot: whole row moves one place toward the head
  // pack: cells from the first hole onward move one place toward the head
  typedef struct packed {
    logic rot;
    logic pack;
  } cell_ctl_t;

endpackage

// File: hw/rtl/srmt_cell.sv
module srmt_cell (
  input  logic                clk,
  input  srmt_pkg::cell_ctl_t ctl,
  input  srmt_pkg::entry_t    right_entry,
  input  logic                right_hole,
  input  logic                shift_in,
  output srmt_pkg::entry_t    entry,
  output logic                hole,
  output logic                shift_out
);
  import srmt_pkg::*;

  // once a hole is seen, everything behind it slides forward
  assign shift_out = shift_in | hole;

  always_ff @(posedge clk) begin
    if (ctl.rot || (ctl.pack && shift_out)) begin
      entry <= right_entry;
      hole  <= right_hole;
    end
  end

endmodule

// File: hw/rtl/sorted_range_merge_table_unit.sv
// Sorted range merge table: up to 32 mappings (physical start, virtual start,
// length) kept in ascending physical order in a ring of 32 entry cells. Cell 0
// is the head; on every rotate step each cell takes its right neighbor's entry
// and the last cell takes the entry the controller writes back, so one full
// lap visits every position in order and leaves the table in place.
// One transaction at a time. Steps, input accept to result valid: add =
// scan lap, decide, write-back lap, finish; a merge adds two arithmetic steps
// before the write-back, and an add dropped on a full table skips the write-back
// lap; filter = process lap, compaction lap, finish; read = one lap, finish;
// clear = finish only. The laps are paced by the one-entry-per-cycle walk
// of the cell ring. The result sits in an output register, so a new
// transaction is taken while the previous result still waits for its sink.
// All address sums wrap modulo 2^64. A filter also drops the last-hit marker.
module sorted_range_merge_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [63:0] start_addr,
  input  logic [63:0] virt_start,
  input  logic [63:0] span,
  input  logic [4:0]  read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] entry_phys,
  output logic [63:0] entry_virt,
  output logic [63:0] entry_span,
  output logic        entry_valid,
  output logic [5:0]  entry_count,
  output logic        overflow
);
  import srmt_pkg::*;

  state_t state, state_next;

  // table bookkeeping
  logic [CNT_W-1:0] count;
  logic [LAP_W-1:0] last_hit;
  logic             lh_valid;

  // captured transaction
  logic [63:0] p_r, v_r, len_r;
  logic [63:0] end_r;   // p + len (add range end, filter window end)
  logic [63:0] vlen_r;  // v + len
  logic [4:0]  idx_r;

  // lap position
  logic [LAP_W-1:0] j;
  logic             lap_end;

  // add scan results
  logic             lh_ext;
  logic             found;
  act_t             found_kind;
  logic [LAP_W-1:0] found_idx;
  logic             stop;
  logic [CNT_W-1:0] ins_pos;
  logic             ins_set;
  entry_t           mh;
  logic [63:0]      m_virt, m_span;

  // apply
  act_t             act;
  logic [LAP_W-1:0] tgt;
  logic             upd_lh;
  entry_t           hold;
  logic             holding;
  logic [CNT_W-1:0] kept;

  // result staging
  entry_t res_entry;
  logic   res_valid;
  logic   res_ovf;

  // cell row
  entry_t    cell_q [MAX_ENTRIES];
  logic      hole_q [MAX_ENTRIES];
  logic      sh     [MAX_ENTRIES];
  cell_ctl_t ctl;
  entry_t    tail;
  logic      tail_hole;
  entry_t    head;

  assign head    = cell_q[0];
  assign lap_end = (j == LAP_W'(MAX_ENTRIES - 1));

  genvar k;
  generate
    for (k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      entry_t rin;
      logic   rhole;
      logic   sin;
      if (k == MAX_ENTRIES - 1) begin : g_last
        assign rin   = tail;
        assign rhole = tail_hole;
      end else begin : g_mid
        assign rin   = cell_q[k+1];
        assign rhole = hole_q[k+1];
      end
      if (k == 0) begin : g_first
        assign sin = 1'b0;
      end else begin : g_rest
        assign sin = sh[k-1];
      end
      srmt_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .right_entry(rin),
        .right_hole (rhole),
        .shift_in   (sin),
        .entry      (cell_q[k]),
        .hole       (hole_q[k]),
        .shift_out  (sh[k])
      );
    end
  endgenerate

  // head inspection
  logic [63:0] hend, vend;
  logic        j_in, follows, overlap, same_off, ends_below;
  assign hend       = head.phys + head.span;
  assign vend       = head.virt + head.span;
  assign j_in       = CNT_W'(j) < count;
  assign follows    = (p_r == hend) && (v_r == vend);
  assign ends_below = end_r < head.phys;
  assign overlap    = !(p_r >= hend);
  assign same_off   = (v_r - head.virt) == (p_r - head.phys);

  // filter clipping; after a front clip alone the entry still ends at hend
  logic        f_drop, f_front;
  entry_t      f_entry;
  logic [63:0] f_phys;
  assign f_drop  = !j_in || (head.phys >= end_r) || (hend <= p_r);
  assign f_front = head.phys < p_r;
  assign f_phys  = f_front ? p_r : head.phys;
  always_comb begin
    f_entry.phys = f_phys;
    f_entry.virt = (f_front && head.virt != 64'd0) ? head.virt + (p_r - head.phys)
                                                    : head.virt;
    if (hend > end_r) begin
      f_entry.span = end_r - f_phys;
    end else begin
      f_entry.span = f_front ? hend - p_r : head.span;
    end
  end

  // add decision from the scan flags
  act_t             dec_act;
  logic [LAP_W-1:0] dec_tgt;
  logic             dec_upd;
  logic             full;
  assign full = (count == CNT_W'(MAX_ENTRIES));
  always_comb begin
    dec_act = ACT_INS;
    dec_tgt = LAP_W'(ins_pos);
    dec_upd = 1'b1;
    if (count != '0) begin
      if (lh_ext) begin
        dec_act = ACT_EXT;
        dec_tgt = last_hit;
        dec_upd = 1'b0;
      end else if (found) begin
        dec_act = found_kind;
        dec_tgt = found_idx;
      end
    end
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(operation))
            OP_ADD:    state_next = ST_ADD_SCAN;
            OP_FILTER: state_next = ST_FILT_LAP;
            OP_READ:   state_next = ST_READ_LAP;
            OP_CLEAR:  state_next = ST_FINISH;
            default:   state_next = ST_FINISH;
          endcase
        end
      end
      ST_ADD_SCAN:   if (lap_end) state_next = ST_ADD_DECIDE;
      ST_ADD_DECIDE: begin
        if (dec_act == ACT_INS && full) begin
          state_next = ST_FINISH;
        end else if (dec_act == ACT_MERGE) begin
          state_next = ST_MERGE_A;
        end else begin
          state_next = ST_ADD_APPLY;
        end
      end
      ST_MERGE_A:    state_next = ST_MERGE_B;
      ST_MERGE_B:    state_next = ST_ADD_APPLY;
      ST_ADD_APPLY:  if (lap_end) state_next = ST_FINISH;
      ST_FILT_LAP:   if (lap_end) state_next = ST_FILT_PACK;
      ST_FILT_PACK:  if (lap_end) state_next = ST_FINISH;
      ST_READ_LAP:   if (lap_end) state_next = ST_FINISH;
      ST_FINISH:     if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // outputs to the cell row
  always_comb begin
    in_stall  = (state != ST_IDLE);
    ctl.rot   = 1'b0;
    ctl.pack  = 1'b0;
    tail      = head;
    tail_hole = 1'b0;
    unique case (state)
      ST_ADD_SCAN, ST_READ_LAP: ctl.rot = 1'b1;
      ST_ADD_APPLY: begin
        ctl.rot = 1'b1;
        if (j == tgt) begin
          unique case (act)
            ACT_EXT:   tail.span = head.span + len_r;
            ACT_MERGE: begin
              tail.virt = m_virt;
              tail.span = m_span;
            end
            ACT_INS: begin
              tail.phys = p_r;
              tail.virt = v_r;
              tail.span = len_r;
            end
            default: tail = head;
          endcase
        end else if (holding) begin
          tail = hold;
        end
      end
      ST_FILT_LAP: begin
        ctl.rot   = 1'b1;
        tail      = f_entry;
        tail_hole = f_drop;
      end
      ST_FILT_PACK: begin
        ctl.pack  = 1'b1;
        tail_hole = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      last_hit  <= '0;
      lh_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            p_r       <= start_addr;
            v_r       <= virt_start;
            len_r     <= span;
            end_r     <= start_addr + span;
            vlen_r    <= virt_start + span;
            idx_r     <= read_index;
            j         <= '0;
            lh_ext    <= 1'b0;
            found     <= 1'b0;
            stop      <= 1'b0;
            ins_pos   <= count;
            ins_set   <= 1'b0;
            holding   <= 1'b0;
            kept      <= '0;
            res_entry <= '0;
            res_valid <= 1'b0;
            res_ovf   <= 1'b0;
            if (op_t'(operation) == OP_CLEAR) begin
              count    <= '0;
              last_hit <= '0;
              lh_valid <= 1'b0;
            end
          end
        end

        ST_ADD_SCAN: begin
          j <= j + 1'b1;
          if (j_in) begin
            if (lh_valid && j == last_hit && follows) lh_ext <= 1'b1;
            if (!ins_set && head.phys >= p_r) begin
              ins_pos <= CNT_W'(j);
              ins_set <= 1'b1;
            end
            if (!stop) begin
              if (follows) begin
                found      <= 1'b1;
                found_kind <= ACT_EXT;
                found_idx  <= j;
                stop       <= 1'b1;
              end else if (ends_below) begin
                stop <= 1'b1;
              end else if (overlap && same_off) begin
                found      <= 1'b1;
                found_kind <= ACT_MERGE;
                found_idx  <= j;
                mh         <= head;
                stop       <= 1'b1;
              end
            end
          end
        end

        ST_ADD_DECIDE: begin
          j      <= '0;
          act    <= dec_act;
          tgt    <= dec_tgt;
          upd_lh <= dec_upd;
          if (dec_act == ACT_INS && full) res_ovf <= 1'b1;
        end

        ST_MERGE_A: begin
          // grow the front when the new range starts lower
          if (v_r < mh.virt) begin
            m_virt <= v_r;
            m_span <= mh.span + (mh.virt - v_r);
          end else begin
            m_virt <= mh.virt;
            m_span <= mh.span;
          end
        end

        ST_MERGE_B: begin
          if (vlen_r > m_virt + m_span) m_span <= vlen_r - m_virt;
        end

        ST_ADD_APPLY: begin
          j <= j + 1'b1;
          if (act == ACT_INS && (j == tgt || holding)) begin
            hold    <= head;
            holding <= 1'b1;
          end
          if (lap_end) begin
            if (act == ACT_INS) count <= count + 1'b1;
            if (upd_lh) begin
              last_hit <= tgt;
              lh_valid <= 1'b1;
            end
          end
        end

        ST_FILT_LAP: begin
          j <= j + 1'b1;
          if (!f_drop) kept <= kept + 1'b1;
        end

        ST_FILT_PACK: begin
          j <= j + 1'b1;
          if (lap_end) begin
            count    <= kept;
            last_hit <= '0;
            lh_valid <= 1'b0;
          end
        end

        ST_READ_LAP: begin
          j <= j + 1'b1;
          if (32'(j) == 32'(idx_r) && 32'(idx_r) < 32'(count)) begin
            res_entry <= head;
            res_valid <= 1'b1;
          end
        end

        ST_FINISH: begin
          if (out_free) begin
            entry_phys  <= res_entry.phys;
            entry_virt  <= res_entry.virt;
            entry_span  <= res_entry.span;
            entry_valid <= res_valid;
            entry_count <= 6'(count);
            overflow    <= res_ovf;
          end
        end

        default: ;
      endcase
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import srmt_pkg::*;

  // One expected result of the table, as seen on the result ports.
  typedef struct {
    logic [63:0] phys;
    logic [63:0] virt;
    logic [63:0] span;
    logic        valid;
    logic [5:0]  count;
    logic        ovf;
  } table_result_t;

  // Shadow copy of the mapping table. Every accepted transaction is applied
  // here and its expected result is queued; results are checked in order.
  class range_table_sb;
    logic [63:0]   phys_q[MAX_ENTRIES];
    logic [63:0]   virt_q[MAX_ENTRIES];
    logic [63:0]   span_q[MAX_ENTRIES];
    int unsigned   used;
    int unsigned   hit_pos;
    bit            hit_ok;
    table_result_t pending[$];
    int            errors;

    function bit adjoins(int unsigned i, logic [63:0] p, logic [63:0] v);
      return p == phys_q[i] + span_q[i] && v == virt_q[i] + span_q[i];
    endfunction

    // Returns 1 when the table is full and the range is dropped.
    function bit place_new(logic [63:0] p, logic [63:0] v, logic [63:0] len);
      int unsigned pos;
      pos = used;
      if (used >= MAX_ENTRIES) return 1;
      for (int unsigned i = 0; i < used; i++)
        if (phys_q[i] >= p) begin
          pos = i;
          break;
        end
      for (int unsigned i = used; i > pos; i--) begin
        phys_q[i] = phys_q[i-1];
        virt_q[i] = virt_q[i-1];
        span_q[i] = span_q[i-1];
      end
      phys_q[pos] = p;
      virt_q[pos] = v;
      span_q[pos] = len;
      used++;
      hit_pos = pos;
      hit_ok = 1;
      return 0;
    endfunction

    function bit add_mapping(logic [63:0] p, logic [63:0] v, logic [63:0] len);
      if (used == 0) return place_new(p, v, len);
      // fast path: range continues the entry hit last time
      if (hit_ok && hit_pos < used && adjoins(hit_pos, p, v)) begin
        span_q[hit_pos] += len;
        return 0;
      end
      for (int unsigned i = 0; i < used; i++) begin
        if (adjoins(i, p, v)) begin
          span_q[i] += len;
          hit_pos = i;
          hit_ok = 1;
          return 0;
        end
        if (p + len < phys_q[i]) break;
        if (!(p >= phys_q[i] + span_q[i])) begin
          // overlap with another offset: skip it and keep scanning
          if (v - virt_q[i] != p - phys_q[i]) continue;
          if (v < virt_q[i]) begin
            span_q[i] += virt_q[i] - v;
            virt_q[i] = v;
          end
          if (v + len > virt_q[i] + span_q[i]) span_q[i] = v + len - virt_q[i];
          hit_pos = i;
          hit_ok = 1;
          return 0;
        end
      end
      return place_new(p, v, len);
    endfunction

    function void clip_to_window(logic [63:0] lo, logic [63:0] len);
      logic [63:0] hi, p, v, s;
      int unsigned kept;
      hi = lo + len;
      kept = 0;
      for (int unsigned i = 0; i < used; i++) begin
        p = phys_q[i];
        v = virt_q[i];
        s = span_q[i];
        if (p >= hi || p + s <= lo) continue;
        if (p < lo) begin
          s -= lo - p;
          if (v != 0) v += lo - p;  // zero virtual start stays put
          p = lo;
        end
        if (p + s > hi) s -= p + s - lo - len;
        phys_q[kept] = p;
        virt_q[kept] = v;
        span_q[kept] = s;
        kept++;
      end
      used = kept;
      hit_pos = 0;
      hit_ok = 0;
    endfunction

    function void note_input(op_t op, logic [63:0] a, logic [63:0] v,
                             logic [63:0] len, logic [4:0] idx);
      table_result_t r;
      r = '{64'd0, 64'd0, 64'd0, 1'b0, 6'd0, 1'b0};
      case (op)
        OP_ADD:    r.ovf = add_mapping(a, v, len);
        OP_FILTER: clip_to_window(a, len);
        OP_READ: begin
          if (idx < used) begin
            r.phys = phys_q[idx];
            r.virt = virt_q[idx];
            r.span = span_q[idx];
            r.valid = 1'b1;
          end
        end
        default: begin
          used = 0;
          hit_pos = 0;
          hit_ok = 0;
        end
      endcase
      r.count = used[5:0];
      pending.push_back(r);
    endfunction

    function void check_result(table_result_t got);
      table_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.phys !== e.phys) begin
        $error("entry_phys exp %h got %h", e.phys, got.phys); errors++;
      end
      if (got.virt !== e.virt) begin
        $error("entry_virt exp %h got %h", e.virt, got.virt); errors++;
      end
      if (got.span !== e.span) begin
        $error("entry_span exp %h got %h", e.span, got.span); errors++;
      end
      if (got.valid !== e.valid) begin
        $error("entry_valid exp %0d got %0d", e.valid, got.valid); errors++;
      end
      if (got.count !== e.count) begin
        $error("entry_count exp %0d got %0d", e.count, got.count); errors++;
      end
      if (got.ovf !== e.ovf) begin
        $error("overflow exp %0d got %0d", e.ovf, got.ovf); errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 800000;

  logic        clk = 0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic [63:0] start_addr;
  logic [63:0] virt_start;
  logic [63:0] span;
  logic [4:0]  read_index;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] entry_phys;
  logic [63:0] entry_virt;
  logic [63:0] entry_span;
  logic        entry_valid;
  logic [5:0]  entry_count;
  logic        overflow;

  range_table_sb sb = new();

  // sender burst state and the request for one long output hold-off
  int          burst_left;
  bit          hold_req;
  // last added range, used to build contiguous and overlapping adds
  logic [63:0] last_p, last_v, last_len;
  int          cycles;

  always #5 clk = ~clk;

  sorted_range_merge_table_unit dut (.*);

  // Input monitor: note every accepted transaction in the shadow table.
  always @(posedge clk)
    if (!rst && in_valid && !in_stall)
      sb.note_input(op_t'(operation), start_addr, virt_start, span, read_index);

  // Output monitor: compare every accepted result with the oldest expectation.
  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_result('{entry_phys, entry_virt, entry_span, entry_valid,
                        entry_count, overflow});

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result sink: stall pattern is redrawn periodically from none, light, heavy,
  // plus one long hold-off so the block backs up and stalls its input.
  initial begin
    int mode, left, hold;
    out_stall <= 1'b0;
    mode = 0;
    left = 64;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold == 0) begin
        hold = 3000;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        if (--left == 0) begin
          mode = $urandom_range(0, 2);
          left = 64;
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // Offer one transaction and wait for it to be taken. Between bursts the
  // valid drops for a random gap; inside a burst it stays high.
  task automatic send(op_t op, logic [63:0] a, logic [63:0] v,
                      logic [63:0] len, logic [4:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid   <= 1'b1;
    operation  <= op;
    start_addr <= a;
    virt_start <= v;
    span       <= len;
    read_index <= idx;
    do @(posedge clk); while (in_stall);
    if (op == OP_ADD) begin
      last_p = a;
      last_v = v;
      last_len = len;
    end
  endtask

  task automatic add(logic [63:0] a, logic [63:0] v, logic [63:0] len);
    send(OP_ADD, a, v, len, 5'd0);
  endtask

  // Small address pool so adds overlap, touch and merge often.
  function automatic logic [63:0] pool_addr();
    logic [63:0] base;
    base = ($urandom_range(0, 5) == 0) ? 64'hFFFF_FFFF_FFFF_F000 : 64'h0;
    return base + 64'($urandom_range(0, 63)) * 64'h40;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_item();
    int sel;
    logic [63:0] p, v, len;
    sel = $urandom_range(0, 99);
    if (sel < 22) begin
      // contiguous with the last add in both spaces
      add(last_p + last_len, last_v + last_len, 64'($urandom_range(1, 'h80)));
    end else if (sel < 34) begin
      // overlap with the last add, same offset (sometimes shifted lower)
      p = last_p + 64'($urandom_range(0, 'h40)) - 64'h20;
      add(p, last_v + (p - last_p), 64'($urandom_range(1, 'h100)));
    end else if (sel < 50) begin
      p = pool_addr();
      v = ($urandom_range(0, 3) == 0) ? 64'h0 : pool_addr();
      add(p, v, 64'($urandom_range(0, 'h100)));
    end else if (sel < 55) begin
      add(rand64(), rand64(), rand64());
    end else if (sel < 78) begin
      send(OP_READ, rand64(), rand64(), rand64(), 5'($urandom_range(0, 31)));
    end else if (sel < 86) begin
      len = ($urandom_range(0, 4) == 0) ? rand64() : 64'($urandom_range(0, 'h1000));
      send(OP_FILTER, pool_addr(), rand64(), len, 5'($urandom()));
    end else if (sel < 89) begin
      send(OP_CLEAR, rand64(), rand64(), rand64(), 5'($urandom()));
    end else begin
      // dense fill: disjoint ranges with distinct offsets, runs into overflow
      for (int i = 0; i < 36; i++) begin
        p = 64'(i) * 64'h1_0000 + 64'h8000;
        add(p, p + 64'($urandom_range(1, 1000)) * 64'h100_0000, 64'h10);
      end
    end
  endtask

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    operation  <= OP_READ;
    start_addr <= '0;
    virt_start <= '0;
    span       <= '0;
    read_index <= '0;
    cycles     <= 0;
    burst_left = 0;
    hold_req   = 0;
    last_p = 0; last_v = 0; last_len = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-table add, extension, insertion, merges, conflicts,
    // reads past the end, clipping filters, wrapping ends, clear.
    add(64'h1000, 64'h5000, 64'h100);
    send(OP_READ, 0, 0, 0, 5'd0);
    add(64'h1100, 64'h5100, 64'h80);                  // extends last hit
    add(64'h0200, 64'h0000, 64'h100);                 // inserts at head
    add(64'h0F80, 64'h4F80, 64'h100);                 // overlaps, same offset
    add(64'h1050, 64'h9999, 64'h10);                  // overlaps, other offset
    add(64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FF00, 64'h200); // wraps
    send(OP_READ, 0, 0, 0, 5'd1);
    send(OP_READ, 0, 0, 0, 5'd2);
    send(OP_READ, 0, 0, 0, 5'd31);                    // past the end
    add(64'h0, 64'h0, 64'h0);
    add(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send(OP_FILTER, 64'h0280, 0, 64'hF00, 5'd0);      // clips both ends
    for (int i = 0; i < 4; i++) send(OP_READ, 0, 0, 0, 5'(i));
    add(64'h3000, 64'h3000, 64'h10);
    send(OP_FILTER, 64'hFFFF_FFFF_FFFF_F000, 0, 64'h4000, 5'd0); // wrapping window
    send(OP_READ, 0, 0, 0, 5'd0);
    send(OP_CLEAR, 0, 0, 0, 5'd0);
    send(OP_READ, 0, 0, 0, 5'd0);

    for (int n = 0; n < 80; n++) begin
      if (n == 20) hold_req = 1;
      random_item();
    end
    in_valid <= 1'b0;

    wait (sb.pending.size() == 0);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
